FILE: sv/flha_pkg.sv
// Shared types, widths and codes for the free-list heap allocator.
// No dependencies; every other file refers to it by scoped names.
package flha_pkg;

    // Table geometry
    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int UNIT_W = 15;
    localparam int BYTE_W = 23;
    localparam int KIND_W = 3;
    localparam int STAT_W = 3;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // One block table entry
    typedef struct packed {
        unit_t start;
        unit_t size;
        logic  used;
    } entry_t;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_FIRST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LAST  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FREE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADARG = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREED  = 3'd4;

    // Configuration registers
    localparam logic  CFG_BASE       = 1'b0;
    localparam logic  CFG_SIZE       = 1'b1;
    localparam unit_t BASE_RST       = 15'd512;
    localparam unit_t SIZE_RST       = 15'd3328;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLAN,
        S_MOVE,
        S_WRITE,
        S_STATS,
        S_DONE
    } state_t;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_PLAN,
        OP_MOVE,
        OP_WRITE,
        OP_STAT_START,
        OP_STAT,
        OP_FINISH
    } dp_op_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic pass_done;
        logic move_done;
        logic write_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: sv/flha_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on flha_pkg for field widths.
interface flha_req_if;
    logic                              valid;
    logic                              ready;
    logic [flha_pkg::KIND_W-1:0]       kind;
    logic [flha_pkg::BYTE_W-1:0]       request_bytes;
    logic [flha_pkg::BYTE_W-1:0]       address;

    modport source (output valid, kind, request_bytes, address, input ready);
    modport sink   (input valid, kind, request_bytes, address, output ready);
endinterface

FILE: sv/flha_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on flha_pkg for field widths.
interface flha_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [flha_pkg::STAT_W-1:0]       status;
    logic [flha_pkg::BYTE_W-1:0]       result_address;
    logic [flha_pkg::BYTE_W-1:0]       block_bytes;
    logic                              block_used;
    logic [flha_pkg::BYTE_W-1:0]       max_free_bytes;
    logic [flha_pkg::BYTE_W-1:0]       total_free_bytes;

    modport source (output valid, status, result_address, block_bytes, block_used,
                    max_free_bytes, total_free_bytes, input ready);
    modport sink   (input valid, status, result_address, block_bytes, block_used,
                    max_free_bytes, total_free_bytes, output ready);
endinterface

FILE: sv/flha_ctrl.sv
// Sequencer for the allocator: scan, plan, move, write, stats, deliver.
// Depends on flha_pkg; drives flha_dp through command/status only.
module flha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  flha_pkg::dp_stat_t st,
    output flha_pkg::dp_op_t   op
);

    flha_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= flha_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        op         = flha_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            flha_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = flha_pkg::OP_LOAD;
                    state_next = flha_pkg::S_SCAN;
                end
            end
            flha_pkg::S_SCAN:
            begin
                op = flha_pkg::OP_SCAN;
                if (st.pass_done)
                    state_next = flha_pkg::S_PLAN;
            end
            flha_pkg::S_PLAN:
            begin
                op         = flha_pkg::OP_PLAN;
                state_next = flha_pkg::S_MOVE;
            end
            flha_pkg::S_MOVE:
            begin
                op = flha_pkg::OP_MOVE;
                if (st.move_done)
                    state_next = flha_pkg::S_WRITE;
            end
            flha_pkg::S_WRITE:
            begin
                if (st.write_done)
                begin
                    op         = flha_pkg::OP_STAT_START;
                    state_next = flha_pkg::S_STATS;
                end
                else
                    op = flha_pkg::OP_WRITE;
            end
            flha_pkg::S_STATS:
            begin
                op = flha_pkg::OP_STAT;
                if (st.pass_done)
                    state_next = flha_pkg::S_DONE;
            end
            flha_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    op         = flha_pkg::OP_FINISH;
                    state_next = flha_pkg::S_IDLE;
                end
            end
            default:
                state_next = flha_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: sv/flha_dp.sv
// Datapath: block table memory, scan evaluation, edit plan, tail moves,
// free-space statistics and the result register. Depends on flha_pkg.
module flha_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  flha_pkg::dp_op_t              op,
    output flha_pkg::dp_stat_t            st,
    input  logic [flha_pkg::KIND_W-1:0]   in_kind,
    input  logic [flha_pkg::BYTE_W-1:0]   in_req,
    input  logic [flha_pkg::BYTE_W-1:0]   in_addr,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [flha_pkg::UNIT_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [flha_pkg::STAT_W-1:0]   out_status,
    output logic [flha_pkg::BYTE_W-1:0]   out_raddr,
    output logic [flha_pkg::BYTE_W-1:0]   out_bbytes,
    output logic                          out_bused,
    output logic [flha_pkg::BYTE_W-1:0]   out_max,
    output logic [flha_pkg::BYTE_W-1:0]   out_tot
);

    // Configuration and table occupancy
    flha_pkg::unit_t base_reg, size_reg;
    logic            init_reg;
    flha_pkg::cnt_t  n_reg;

    // Request word
    logic [flha_pkg::KIND_W-1:0] kind_reg;
    logic [flha_pkg::UNIT_W:0]   bsize_reg;
    flha_pkg::unit_t             ba_reg;
    logic                        mis_reg;

    // Pass pointer and read pipeline
    flha_pkg::cnt_t  ptr_reg, cnt_reg;
    logic            rv_reg;
    flha_pkg::idx_t  rj_reg;
    flha_pkg::entry_t mem [flha_pkg::SLOTS];
    flha_pkg::entry_t mq_reg;
    logic            ri_reg;

    // Scan results
    logic             found_reg, stop_reg, pv_reg, nv_reg;
    flha_pkg::idx_t   hit_reg;
    flha_pkg::entry_t he_reg, pe_reg, pn_reg, nx_reg;

    // Edit plan
    flha_pkg::entry_t e_reg [3];
    logic [1:0]       ne_reg, wk_reg, d_reg;
    flha_pkg::idx_t   wpos_reg;
    logic             down_reg;
    flha_pkg::cnt_t   nnew_reg;
    logic [flha_pkg::STAT_W-1:0] rs_reg;
    flha_pkg::unit_t  ra_reg, rb_reg;
    logic             ru_reg;

    // Statistics
    flha_pkg::unit_t tot_reg, max_reg;

    // Result register
    logic                        ov_reg;
    logic [flha_pkg::STAT_W-1:0] os_reg;
    flha_pkg::unit_t             oa_reg, ob_reg, om_reg, ot_reg;
    logic                        ou_reg;

    flha_pkg::entry_t e;
    logic             rd_en, wr_en;
    flha_pkg::idx_t   rd_idx, wr_idx;
    flha_pkg::entry_t wr_data;

    // Returned entry; slot 0 reads as the whole arena until first written
    assign e = ri_reg ? '{start: base_reg, size: size_reg, used: 1'b0} : mq_reg;

    // Read issue
    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = ptr_reg[flha_pkg::IDX_W-1:0];
        case (op)
            flha_pkg::OP_SCAN, flha_pkg::OP_STAT: rd_en = (ptr_reg < n_reg);
            flha_pkg::OP_MOVE:                    rd_en = (cnt_reg != '0);
            default:                              rd_en = 1'b0;
        endcase
    end

    // Write port: moved entries or planned entries
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = rj_reg;
        wr_data = e;
        if (op == flha_pkg::OP_MOVE && rv_reg)
        begin
            wr_en  = 1'b1;
            wr_idx = down_reg ? flha_pkg::idx_t'(rj_reg + flha_pkg::idx_t'(d_reg))
                              : flha_pkg::idx_t'(rj_reg - flha_pkg::idx_t'(d_reg));
        end
        else if (op == flha_pkg::OP_WRITE && wk_reg < ne_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = flha_pkg::idx_t'(wpos_reg + flha_pkg::idx_t'(wk_reg));
            wr_data = e_reg[wk_reg];
        end
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
            mq_reg <= mem[rd_idx];
        ri_reg <= (rd_idx == '0) && init_reg;
        rj_reg <= rd_idx;
    end

    // Edit plan, worked out from the scan results
    flha_pkg::unit_t s, sz, bs15, tail, sz1;
    flha_pkg::cnt_t  hit_c;
    logic            split1, split2, mn, mp;
    logic [1:0]      need;
    logic [flha_pkg::STAT_W-1:0] p_status;
    flha_pkg::unit_t p_ra, p_rb;
    logic            p_ru, p_down;
    flha_pkg::entry_t p_e0, p_e1, p_e2, ea, eb, ec;
    logic [1:0]      p_ne, p_d;
    flha_pkg::idx_t  p_wpos;
    flha_pkg::cnt_t  p_mvs, p_cnt, p_nnew;

    always_comb
    begin
        s      = he_reg.start;
        sz     = he_reg.size;
        bs15   = bsize_reg[flha_pkg::UNIT_W-1:0];
        hit_c  = flha_pkg::cnt_t'(hit_reg);
        split1 = s < ba_reg;
        tail   = flha_pkg::unit_t'(s + sz - ba_reg);
        split2 = tail != bs15;
        need   = {1'b0, split1} + {1'b0, split2};
        mn     = nv_reg && !nx_reg.used;
        mp     = pv_reg && !pn_reg.used;
        sz1    = mn ? flha_pkg::unit_t'(sz + nx_reg.size) : sz;
        ea     = '{start: s, size: flha_pkg::unit_t'(ba_reg - s), used: 1'b0};
        eb     = '{start: ba_reg, size: bs15, used: 1'b1};
        ec     = '{start: flha_pkg::unit_t'(ba_reg + bs15),
                   size: flha_pkg::unit_t'(tail - bs15), used: 1'b0};
        p_status = flha_pkg::ST_NOFIT;
        p_ra   = '0;
        p_rb   = '0;
        p_ru   = 1'b0;
        p_e0   = he_reg;
        p_e1   = he_reg;
        p_e2   = ec;
        p_ne   = 2'd0;
        p_d    = 2'd0;
        p_down = 1'b1;
        p_wpos = hit_reg;
        p_mvs  = flha_pkg::cnt_t'(n_reg - 1'b1);
        p_cnt  = '0;
        p_nnew = n_reg;
        case (kind_reg)
            flha_pkg::KIND_FIRST, flha_pkg::KIND_LAST:
            begin
                if (bsize_reg == '0)
                    p_status = flha_pkg::ST_BADARG;
                else if (!found_reg)
                    p_status = flha_pkg::ST_NOFIT;
                else if (sz == bs15)
                begin
                    p_status = flha_pkg::ST_OK;
                    p_e0     = '{start: s, size: sz, used: 1'b1};
                    p_ne     = 2'd1;
                    p_ra     = s;
                end
                else if (n_reg == flha_pkg::cnt_t'(flha_pkg::SLOTS))
                    p_status = flha_pkg::ST_FULL;
                else
                begin
                    p_status = flha_pkg::ST_OK;
                    p_ne     = 2'd2;
                    p_d      = 2'd1;
                    p_cnt    = flha_pkg::cnt_t'(n_reg - hit_c - 1'b1);
                    p_nnew   = flha_pkg::cnt_t'(n_reg + 1'b1);
                    if (kind_reg == flha_pkg::KIND_FIRST)
                    begin
                        p_e0 = '{start: s, size: bs15, used: 1'b1};
                        p_e1 = '{start: flha_pkg::unit_t'(s + bs15),
                                 size: flha_pkg::unit_t'(sz - bs15), used: 1'b0};
                        p_ra = s;
                    end
                    else
                    begin
                        p_e0 = '{start: s, size: flha_pkg::unit_t'(sz - bs15), used: 1'b0};
                        p_e1 = '{start: flha_pkg::unit_t'(s + sz - bs15), size: bs15,
                                 used: 1'b1};
                        p_ra = flha_pkg::unit_t'(s + sz - bs15);
                    end
                end
            end
            flha_pkg::KIND_AT:
            begin
                if (bsize_reg == '0 || mis_reg)
                    p_status = flha_pkg::ST_BADARG;
                else if (stop_reg || !found_reg)
                    p_status = flha_pkg::ST_NOFIT;
                else if (({1'b0, n_reg} + (CNT_W1)'(need)) > (CNT_W1)'(flha_pkg::SLOTS))
                    p_status = flha_pkg::ST_FULL;
                else
                begin
                    p_status = flha_pkg::ST_OK;
                    p_ra     = ba_reg;
                    p_e0     = split1 ? ea : eb;
                    p_e1     = split1 ? eb : ec;
                    p_ne     = 2'd1 + need;
                    p_d      = need;
                    p_cnt    = flha_pkg::cnt_t'(n_reg - hit_c - 1'b1);
                    p_nnew   = flha_pkg::cnt_t'(n_reg + flha_pkg::cnt_t'(need));
                end
            end
            flha_pkg::KIND_FREE:
            begin
                if (mis_reg)
                    p_status = flha_pkg::ST_BADARG;
                else if (!found_reg)
                    p_status = flha_pkg::ST_NOFIT;
                else if (!he_reg.used)
                    p_status = flha_pkg::ST_FREED;
                else
                begin
                    p_status = flha_pkg::ST_OK;
                    if (mp)
                    begin
                        p_e0   = '{start: pn_reg.start,
                                   size: flha_pkg::unit_t'(pn_reg.size + sz1), used: 1'b0};
                        p_wpos = flha_pkg::idx_t'(hit_reg - 1'b1);
                    end
                    else
                        p_e0 = '{start: s, size: sz1, used: 1'b0};
                    p_ne   = 2'd1;
                    p_down = 1'b0;
                    p_d    = {1'b0, mn} + {1'b0, mp};
                    p_mvs  = flha_pkg::cnt_t'(hit_c + 1'b1 + flha_pkg::cnt_t'(mn));
                    p_cnt  = flha_pkg::cnt_t'(n_reg - hit_c - 1'b1 - flha_pkg::cnt_t'(mn));
                    p_nnew = flha_pkg::cnt_t'(n_reg - flha_pkg::cnt_t'(p_d));
                end
            end
            flha_pkg::KIND_QUERY:
            begin
                if (found_reg)
                begin
                    p_status = flha_pkg::ST_OK;
                    p_rb     = sz;
                    p_ru     = he_reg.used;
                end
            end
            default:
                p_status = flha_pkg::ST_NOFIT;
        endcase
    end

    localparam int CNT_W1 = flha_pkg::CNT_W + 1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= flha_pkg::BASE_RST;
            size_reg  <= flha_pkg::SIZE_RST;
            init_reg  <= 1'b1;
            n_reg     <= flha_pkg::cnt_t'(1);
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            found_reg <= 1'b0;
            stop_reg  <= 1'b0;
            nv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            wk_reg    <= '0;
            ne_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            rv_reg <= rd_en;
            if (wr_en && wr_idx == '0)
                init_reg <= 1'b0;
            if (rd_en)
            begin
                if (op == flha_pkg::OP_MOVE)
                begin
                    ptr_reg <= down_reg ? flha_pkg::cnt_t'(ptr_reg - 1'b1)
                                        : flha_pkg::cnt_t'(ptr_reg + 1'b1);
                    cnt_reg <= flha_pkg::cnt_t'(cnt_reg - 1'b1);
                end
                else
                    ptr_reg <= flha_pkg::cnt_t'(ptr_reg + 1'b1);
            end
            case (op)
                flha_pkg::OP_LOAD:
                begin
                    ptr_reg   <= '0;
                    found_reg <= 1'b0;
                    stop_reg  <= 1'b0;
                    nv_reg    <= 1'b0;
                    pv_reg    <= 1'b0;
                end
                flha_pkg::OP_SCAN:
                begin
                    if (rv_reg)
                    begin
                        case (kind_reg)
                            flha_pkg::KIND_FIRST:
                                if (!found_reg && !e.used && {1'b0, e.size} >= bsize_reg)
                                    found_reg <= 1'b1;
                            flha_pkg::KIND_LAST:
                                if (!e.used && {1'b0, e.size} >= bsize_reg)
                                    found_reg <= 1'b1;
                            flha_pkg::KIND_AT:
                                if (!found_reg && !stop_reg)
                                begin
                                    if (ba_reg < e.start)
                                        stop_reg <= 1'b1;
                                    else if (!e.used && ({2'b0, e.start} + {2'b0, e.size}) >=
                                             ({2'b0, ba_reg} + {1'b0, bsize_reg}))
                                        found_reg <= 1'b1;
                                end
                            flha_pkg::KIND_FREE:
                            begin
                                if (!found_reg && e.start == ba_reg)
                                begin
                                    found_reg <= 1'b1;
                                    pv_reg    <= rj_reg != '0;
                                end
                                if (found_reg && rj_reg == flha_pkg::idx_t'(hit_reg + 1'b1))
                                    nv_reg <= 1'b1;
                            end
                            flha_pkg::KIND_QUERY:
                                if (!found_reg && ba_reg >= e.start &&
                                    {1'b0, ba_reg} < ({1'b0, e.start} + {1'b0, e.size}))
                                    found_reg <= 1'b1;
                            default:
                                found_reg <= 1'b0;
                        endcase
                    end
                end
                flha_pkg::OP_PLAN:
                begin
                    ptr_reg <= p_mvs;
                    cnt_reg <= p_cnt;
                    ne_reg  <= p_ne;
                    wk_reg  <= '0;
                end
                flha_pkg::OP_WRITE:
                    wk_reg <= wk_reg + 1'b1;
                flha_pkg::OP_STAT_START:
                begin
                    n_reg   <= nnew_reg;
                    ptr_reg <= '0;
                end
                default:
                    wk_reg <= wk_reg;
            endcase
            // Result register
            if (op == flha_pkg::OP_FINISH)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            // Configuration writes reinitialize the table
            if (cfg_we)
            begin
                if (cfg_index == flha_pkg::CFG_BASE)
                begin
                    base_reg <= cfg_data;
                    n_reg    <= flha_pkg::cnt_t'(size_reg != '0);
                end
                else
                begin
                    size_reg <= cfg_data;
                    n_reg    <= flha_pkg::cnt_t'(cfg_data != '0);
                end
                init_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            flha_pkg::OP_LOAD:
            begin
                kind_reg  <= in_kind;
                bsize_reg <= 16'(({1'b0, in_req} + 24'd255) >> 8);
                ba_reg    <= in_addr[flha_pkg::BYTE_W-1:8];
                mis_reg   <= |in_addr[7:0];
            end
            flha_pkg::OP_SCAN:
            begin
                if (rv_reg)
                begin
                    pe_reg <= e;
                    case (kind_reg)
                        flha_pkg::KIND_FIRST:
                            if (!found_reg && !e.used && {1'b0, e.size} >= bsize_reg)
                            begin
                                hit_reg <= rj_reg;
                                he_reg  <= e;
                            end
                        flha_pkg::KIND_LAST:
                            if (!e.used && {1'b0, e.size} >= bsize_reg)
                            begin
                                hit_reg <= rj_reg;
                                he_reg  <= e;
                            end
                        flha_pkg::KIND_AT:
                            if (!found_reg && !stop_reg && ba_reg >= e.start)
                            begin
                                hit_reg <= rj_reg;
                                he_reg  <= e;
                            end
                        flha_pkg::KIND_FREE:
                        begin
                            if (!found_reg && e.start == ba_reg)
                            begin
                                hit_reg <= rj_reg;
                                he_reg  <= e;
                                pn_reg  <= pe_reg;
                            end
                            if (found_reg && rj_reg == flha_pkg::idx_t'(hit_reg + 1'b1))
                                nx_reg <= e;
                        end
                        flha_pkg::KIND_QUERY:
                            if (!found_reg)
                                he_reg <= e;
                        default:
                            he_reg <= he_reg;
                    endcase
                end
            end
            flha_pkg::OP_PLAN:
            begin
                e_reg[0] <= p_e0;
                e_reg[1] <= p_e1;
                e_reg[2] <= p_e2;
                d_reg    <= p_d;
                down_reg <= p_down;
                wpos_reg <= p_wpos;
                nnew_reg <= p_nnew;
                rs_reg   <= p_status;
                ra_reg   <= (p_status == flha_pkg::ST_OK) ? p_ra : '0;
                rb_reg   <= p_rb;
                ru_reg   <= p_ru;
            end
            flha_pkg::OP_STAT_START:
            begin
                tot_reg <= '0;
                max_reg <= '0;
            end
            flha_pkg::OP_STAT:
            begin
                if (rv_reg && !e.used)
                begin
                    tot_reg <= flha_pkg::unit_t'(tot_reg + e.size);
                    if (e.size > max_reg)
                        max_reg <= e.size;
                end
            end
            flha_pkg::OP_FINISH:
            begin
                os_reg <= rs_reg;
                oa_reg <= ra_reg;
                ob_reg <= rb_reg;
                ou_reg <= ru_reg;
                om_reg <= max_reg;
                ot_reg <= tot_reg;
            end
            default:
                os_reg <= os_reg;
        endcase
    end

    // Status to the controller
    assign st.pass_done  = (ptr_reg >= n_reg) && !rv_reg;
    assign st.move_done  = (cnt_reg == '0) && !rv_reg;
    assign st.write_done = wk_reg >= ne_reg;
    assign st.out_free   = !ov_reg || out_ready;

    // Result word
    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_raddr  = {oa_reg, 8'h00};
    assign out_bbytes = {ob_reg, 8'h00};
    assign out_bused  = ou_reg;
    assign out_max    = {om_reg, 8'h00};
    assign out_tot    = {ot_reg, 8'h00};

endmodule

FILE: sv/free_list_heap_allocator_core.sv
// Free-list heap allocator over an address-ordered block table.
// Channels: req (sink) takes one request word {kind, request_bytes, address};
// rsp (source) returns one result word per request with status, allocated
// address, queried block size and used flag, largest and total free space.
// Both use valid/ready; a word moves on a clock edge with both high.
// Config: cfg_we writes cfg_data to register cfg_index (0 arena base,
// 1 arena size, in 256-byte units); each write reinitializes the table.
// Steps, for a table holding n live entries (at most 64): one pass reads the
// table to find the block, one pass moves the later entries through the
// table memory, one pass sums free space.
// One request is handled at a time; req.ready is high only between requests.
// A finished result is held in an output register; a new request may be
// taken while it waits, and the next result waits until rsp.ready.
// Reset: arena base 512, size 3328, table holds one free block, no result
// pending. No clearing pass is needed: the live-entry count hides old data.
// Depends on flha_pkg, flha_req_if, flha_rsp_if, flha_ctrl and flha_dp.
module free_list_heap_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    flha_req_if.sink                    req,
    flha_rsp_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [flha_pkg::UNIT_W-1:0] cfg_data
);

    flha_pkg::dp_op_t   op;
    flha_pkg::dp_stat_t st;
    logic               in_ready;

    assign req.ready = in_ready;

    flha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .st       (st),
        .op       (op)
    );

    flha_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .st         (st),
        .in_kind    (req.kind),
        .in_req     (req.request_bytes),
        .in_addr    (req.address),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_raddr  (rsp.result_address),
        .out_bbytes (rsp.block_bytes),
        .out_bused  (rsp.block_used),
        .out_max    (rsp.max_free_bytes),
        .out_tot    (rsp.total_free_bytes)
    );

endmodule

FILE: sv/flha_checker.sv
// Port-level checks on the allocator's result channel, bound to the top.
// Depends on flha_pkg and free_list_heap_allocator_core.
module flha_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [flha_pkg::STAT_W-1:0] rsp_status,
    input logic [flha_pkg::BYTE_W-1:0] rsp_raddr,
    input logic [flha_pkg::BYTE_W-1:0] rsp_max,
    input logic [flha_pkg::BYTE_W-1:0] rsp_tot
);

    // Stalled word stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_raddr))
        else $error("result word changed while stalled");

    // Failed requests report no address
    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != flha_pkg::ST_OK |-> rsp_raddr == '0)
        else $error("address reported on a failed request");

    // Largest free block never exceeds total free space
    a_max_tot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_max <= rsp_tot)
        else $error("largest free block above total free space");

endmodule

bind free_list_heap_allocator_core flha_checker u_flha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_raddr  (rsp.result_address),
    .rsp_max    (rsp.max_free_bytes),
    .rsp_tot    (rsp.total_free_bytes)
);
